// ===== hw/rtl/abkf_pkg.sv =====
// shared types, constants and step decode for the angle and bias kalman filter
// no dependencies
package abkf_pkg;

    localparam int ABKF_DATA_WIDTH = 32;
    localparam int ABKF_ADDR_WIDTH = 4;
    localparam int ABKF_NOISE_WIDTH = 31;

    localparam logic [30:0] RESET_ANGLE_NOISE = 31'd16777;
    localparam logic [30:0] RESET_BIAS_NOISE  = 31'd50332;
    localparam logic [30:0] RESET_MEAS_NOISE  = 31'd503316;

    localparam logic [1:0] REG_ANGLE_NOISE = 2'd0;
    localparam logic [1:0] REG_BIAS_NOISE  = 2'd1;
    localparam logic [1:0] REG_MEAS_NOISE  = 2'd2;

    localparam logic ACTION_UPDATE = 1'b0;
    localparam logic ACTION_SET    = 1'b1;

    // update sequence, one shared-unit or alu operation per step
    localparam logic [3:0] STEP_RATE     = 4'd0;
    localparam logic [3:0] STEP_ANGLE    = 4'd1;
    localparam logic [3:0] STEP_T        = 4'd2;
    localparam logic [3:0] STEP_CROSS    = 4'd3;
    localparam logic [3:0] STEP_P00      = 4'd4;
    localparam logic [3:0] STEP_P11      = 4'd5;
    localparam logic [3:0] STEP_INNOV    = 4'd6;
    localparam logic [3:0] STEP_K0       = 4'd7;
    localparam logic [3:0] STEP_K1       = 4'd8;
    localparam logic [3:0] STEP_CORR_A   = 4'd9;
    localparam logic [3:0] STEP_CORR_B   = 4'd10;
    localparam logic [3:0] STEP_SHR_P10  = 4'd11;
    localparam logic [3:0] STEP_SHR_P11  = 4'd12;
    localparam logic [3:0] STEP_SHR_P01  = 4'd13;
    localparam logic [3:0] STEP_SHR_P00  = 4'd14;
    localparam logic [3:0] STEP_LAST     = STEP_SHR_P00;

    typedef enum logic [1:0] {
        KIND_ALU,
        KIND_MUL,
        KIND_DIV
    } step_kind_t;

    typedef struct packed {
        logic                action;
        logic signed [31:0]  new_angle;
        logic signed [31:0]  new_rate;
        logic [23:0]         time_step;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0]  angle_estimate;
        logic signed [31:0]  unbiased_rate;
    } out_word_t;

    typedef struct packed {
        logic        load;
        logic        set_angle;
        logic        start_mul;
        logic        start_div;
        logic        wb;
        logic        publish;
        logic [3:0]  step;
    } dp_cmd_t;

    typedef struct packed {
        logic  is_set;
        logic  mul_done;
        logic  div_done;
    } dp_status_t;

    function automatic step_kind_t step_kind(input logic [3:0] step);
        step_kind_t k;
        case (step)
            STEP_RATE, STEP_CROSS, STEP_INNOV: k = KIND_ALU;
            STEP_K0, STEP_K1:                  k = KIND_DIV;
            default:                           k = KIND_MUL;
        endcase
        return k;
    endfunction

endpackage

// ===== hw/rtl/abkf_mul.sv =====
// multi-cycle unsigned multiplier, 16 bits of the first operand per cycle
// depends on nothing
module abkf_mul #(
    parameter int MW = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [MW-1:0]     a,
    input  logic [MW-1:0]     b,
    output logic [2*MW-1:0]   prod,
    output logic              done
);
    localparam int NCH = (MW + 15) / 16;
    localparam int AP = NCH * 16;
    localparam int PW = AP + MW;
    localparam int CW = $clog2(NCH + 1);

    logic [AP-1:0]    a_reg;
    logic [MW-1:0]    b_reg;
    logic [PW-1:0]    acc_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [MW+15:0]   pp;

    assign pp = (MW+16)'(a_reg[AP-1 -: 16]) * (MW+16)'(b_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CW'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NCH);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= AP'(a);
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            a_reg   <= a_reg << 16;
            acc_reg <= (acc_reg << 16) + PW'(pp);
        end
    end

    assign prod = acc_reg[2*MW-1:0];
    assign done = done_reg;

endmodule

// ===== hw/rtl/abkf_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on nothing
module abkf_div #(
    parameter int NW = 56,
    parameter int DW = 34
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [NW-1:0]   n,
    input  logic [DW-1:0]   d,
    output logic [NW-1:0]   q,
    output logic            done
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0]  n_reg;
    logic [NW-1:0]  q_reg;
    logic [DW-1:0]  d_reg;
    logic [DW-1:0]  rem_reg;
    logic [CW-1:0]  cnt_reg;
    logic           busy_reg;
    logic           done_reg;
    logic [DW:0]    trial;
    logic           ge;

    assign trial = {rem_reg, n_reg[NW-1]};
    assign ge = trial >= {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CW'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg   <= n;
            d_reg   <= d;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            n_reg   <= n_reg << 1;
            rem_reg <= ge ? DW'(trial - {1'b0, d_reg}) : trial[DW-1:0];
            q_reg   <= {q_reg[NW-2:0], ge};
        end
    end

    assign q = q_reg;
    assign done = done_reg;

endmodule

// ===== hw/rtl/abkf_dp.sv =====
// datapath: filter state, working registers, shared multiplier and divider
// depends on abkf_pkg, abkf_mul, abkf_div
module abkf_dp
    import abkf_pkg::*;
#(
    parameter int DATA_WIDTH = ABKF_DATA_WIDTH
) (
    input  logic         clk,
    input  logic         rst_n,
    input  dp_cmd_t      cmd,
    output dp_status_t   status,
    input  in_word_t     item,
    input  logic [30:0]  angle_noise,
    input  logic [30:0]  bias_noise,
    input  logic [30:0]  meas_noise,
    output out_word_t    result
);
    localparam int W  = DATA_WIDTH;
    localparam int MW = (W > 31) ? W : 31;
    localparam int XW = 2 * MW;
    localparam int NW = W + 24;
    localparam int SW = MW + 2;
    localparam int AW = MW + 4;

    localparam logic signed [AW-1:0] HI   = {{(AW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [AW-1:0] LO   = ~HI;
    localparam logic [XW-1:0]        MHI  = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [AW-1:0] HI32 = AW'(32'sh7fffffff);
    localparam logic signed [AW-1:0] LO32 = ~HI32;

    function automatic logic signed [W-1:0] sat_s(input logic signed [AW-1:0] v);
        logic signed [W-1:0] r;
        if (v > HI)
        begin
            r = HI[W-1:0];
        end
        else if (v < LO)
        begin
            r = LO[W-1:0];
        end
        else
        begin
            r = v[W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [W-1:0] sat_m(input logic [XW-1:0] m, input logic neg);
        logic signed [W-1:0] r;
        if (m > MHI)
        begin
            r = neg ? LO[W-1:0] : HI[W-1:0];
        end
        else
        begin
            r = neg ? -m[W-1:0] : m[W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [AW-1:0] ext(input logic signed [W-1:0] v);
        return AW'(v);
    endfunction

    function automatic logic [MW-1:0] mag(input logic signed [W-1:0] v);
        logic [W-1:0] u;
        u = v[W-1] ? (~v + W'(1)) : v;
        return MW'(u);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [AW-1:0] v);
        logic signed [31:0] r;
        if (v > HI32)
        begin
            r = HI32[31:0];
        end
        else if (v < LO32)
        begin
            r = LO32[31:0];
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    logic signed [31:0]    meas_reg;
    logic signed [31:0]    grate_reg;
    logic [23:0]           dt_reg;
    logic                  is_set_reg;
    logic signed [W-1:0]   angle_reg, bias_reg, rate_reg;
    logic signed [W-1:0]   p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [W-1:0]   t_reg, x_reg, y_reg, k0_reg, k1_reg;
    logic signed [SW-1:0]  s_reg;
    out_word_t             result_reg;

    logic [MW-1:0]         mul_a, mul_b;
    logic                  mul_neg;
    logic [XW-1:0]         mul_prod;
    logic                  mul_done;
    logic [XW-1:0]         mul_shifted;
    logic signed [W-1:0]   mres;
    logic [NW-1:0]         div_n;
    logic                  div_neg;
    logic [NW-1:0]         div_q;
    logic                  div_done;
    logic signed [W-1:0]   dres;
    logic                  s_pos;

    logic signed [AW-1:0]  qa_ext, meas_ext, grate_ext;
    logic signed [SW-1:0]  s_calc;

    assign qa_ext    = signed'(AW'(angle_noise));
    assign meas_ext  = AW'(meas_reg);
    assign grate_ext = AW'(grate_reg);
    assign s_calc    = SW'(p00_reg) + signed'(SW'(meas_noise));
    assign s_pos     = !s_reg[SW-1] && (s_reg != '0);

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a   = MW'(dt_reg);
        mul_b   = mag(rate_reg);
        mul_neg = rate_reg[W-1];
        case (cmd.step)
            STEP_ANGLE:
            begin
                mul_b   = mag(rate_reg);
                mul_neg = rate_reg[W-1];
            end
            STEP_T:
            begin
                mul_b   = mag(p11_reg);
                mul_neg = p11_reg[W-1];
            end
            STEP_P00:
            begin
                mul_b   = mag(x_reg);
                mul_neg = x_reg[W-1];
            end
            STEP_P11:
            begin
                mul_b   = MW'(bias_noise);
                mul_neg = 1'b0;
            end
            STEP_CORR_A:
            begin
                mul_a   = mag(k0_reg);
                mul_b   = mag(y_reg);
                mul_neg = k0_reg[W-1] ^ y_reg[W-1];
            end
            STEP_CORR_B:
            begin
                mul_a   = mag(k1_reg);
                mul_b   = mag(y_reg);
                mul_neg = k1_reg[W-1] ^ y_reg[W-1];
            end
            STEP_SHR_P10:
            begin
                mul_a   = mag(k1_reg);
                mul_b   = mag(p00_reg);
                mul_neg = k1_reg[W-1] ^ p00_reg[W-1];
            end
            STEP_SHR_P11:
            begin
                mul_a   = mag(k1_reg);
                mul_b   = mag(p01_reg);
                mul_neg = k1_reg[W-1] ^ p01_reg[W-1];
            end
            STEP_SHR_P01:
            begin
                mul_a   = mag(k0_reg);
                mul_b   = mag(p01_reg);
                mul_neg = k0_reg[W-1] ^ p01_reg[W-1];
            end
            STEP_SHR_P00:
            begin
                mul_a   = mag(k0_reg);
                mul_b   = mag(p00_reg);
                mul_neg = k0_reg[W-1] ^ p00_reg[W-1];
            end
            default:
            begin
                mul_a   = MW'(dt_reg);
            end
        endcase
    end

    always_comb
    begin
        case (cmd.step)
            STEP_ANGLE:  mul_shifted = mul_prod >> 16;
            STEP_CORR_B: mul_shifted = mul_prod >> 32;
            default:     mul_shifted = mul_prod >> 24;
        endcase
    end

    assign mres    = sat_m(mul_shifted, mul_neg);
    assign div_neg = (cmd.step == STEP_K1) ? p10_reg[W-1] : p00_reg[W-1];
    assign div_n   = NW'((cmd.step == STEP_K1) ? mag(p10_reg) : mag(p00_reg)) << 24;
    assign dres    = s_pos ? sat_m(XW'(div_q), div_neg) : '0;

    abkf_mul #(
        .MW (MW)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.start_mul),
        .a     (mul_a),
        .b     (mul_b),
        .prod  (mul_prod),
        .done  (mul_done)
    );

    abkf_div #(
        .NW (NW),
        .DW (SW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.start_div),
        .n     (div_n),
        .d     (s_reg),
        .q     (div_q),
        .done  (div_done)
    );

    // filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg <= '0;
            bias_reg  <= '0;
            rate_reg  <= '0;
            p00_reg   <= '0;
            p01_reg   <= '0;
            p10_reg   <= '0;
            p11_reg   <= '0;
        end
        else if (cmd.set_angle)
        begin
            angle_reg <= sat_s(meas_ext);
        end
        else if (cmd.wb)
        begin
            case (cmd.step)
                STEP_RATE:    rate_reg  <= sat_s(grate_ext - ext(bias_reg));
                STEP_ANGLE:   angle_reg <= sat_s(ext(angle_reg) + ext(mres));
                STEP_CROSS:
                begin
                    p01_reg <= sat_s(ext(p01_reg) - ext(t_reg));
                    p10_reg <= sat_s(ext(p10_reg) - ext(t_reg));
                end
                STEP_P00:     p00_reg   <= sat_s(ext(p00_reg) + ext(mres));
                STEP_P11:     p11_reg   <= sat_s(ext(p11_reg) + ext(mres));
                STEP_CORR_A:  angle_reg <= sat_s(ext(angle_reg) + ext(mres));
                STEP_CORR_B:  bias_reg  <= sat_s(ext(bias_reg) + ext(mres));
                STEP_SHR_P10: p10_reg   <= sat_s(ext(p10_reg) - ext(mres));
                STEP_SHR_P11: p11_reg   <= sat_s(ext(p11_reg) - ext(mres));
                STEP_SHR_P01: p01_reg   <= sat_s(ext(p01_reg) - ext(mres));
                STEP_SHR_P00: p00_reg   <= sat_s(ext(p00_reg) - ext(mres));
                default:
                begin
                end
            endcase
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            meas_reg   <= item.new_angle;
            grate_reg  <= item.new_rate;
            dt_reg     <= item.time_step;
            is_set_reg <= (item.action == ACTION_SET);
        end
        if (cmd.publish)
        begin
            result_reg.angle_estimate <= sat32(ext(angle_reg));
            result_reg.unbiased_rate  <= sat32(ext(rate_reg));
        end
        if (cmd.wb)
        begin
            case (cmd.step)
                STEP_T:     t_reg <= mres;
                STEP_CROSS: x_reg <= sat_s(ext(t_reg) - ext(p01_reg) - ext(p10_reg) + qa_ext);
                STEP_INNOV:
                begin
                    s_reg <= s_calc;
                    y_reg <= sat_s(meas_ext - ext(angle_reg));
                end
                STEP_K0:    k0_reg <= dres;
                STEP_K1:    k1_reg <= dres;
                default:
                begin
                end
            endcase
        end
    end

    assign status.is_set   = is_set_reg;
    assign status.mul_done = mul_done;
    assign status.div_done = div_done;
    assign result = result_reg;

endmodule

// ===== hw/rtl/abkf_ctrl.sv =====
// controller: sequences the update steps and owns both handshakes
// depends on abkf_pkg
module abkf_ctrl
    import abkf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    output logic         item_ready,
    output logic         result_valid,
    input  logic         result_ready,
    output dp_cmd_t      cmd,
    input  dp_status_t   status
);
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_RUN    = 4'b0010,
        ST_WAIT   = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t      state_reg, state_next;
    logic [3:0]  step_reg, step_next;
    logic        valid_reg, valid_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.step   = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    step_next  = STEP_RATE;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (status.is_set)
                begin
                    cmd.set_angle = 1'b1;
                    state_next    = ST_FINISH;
                end
                else
                begin
                    case (step_kind(step_reg))
                        KIND_MUL:
                        begin
                            cmd.start_mul = 1'b1;
                            state_next    = ST_WAIT;
                        end
                        KIND_DIV:
                        begin
                            cmd.start_div = 1'b1;
                            state_next    = ST_WAIT;
                        end
                        default:
                        begin
                            cmd.wb    = 1'b1;
                            step_next = step_reg + 4'd1;
                            if (step_reg == STEP_LAST)
                            begin
                                state_next = ST_FINISH;
                            end
                        end
                    endcase
                end
            end
            ST_WAIT:
            begin
                if (status.mul_done || status.div_done)
                begin
                    cmd.wb     = 1'b1;
                    step_next  = step_reg + 4'd1;
                    state_next = (step_reg == STEP_LAST) ? ST_FINISH : ST_RUN;
                end
            end
            ST_FINISH:
            begin
                if (!valid_reg)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.publish)
        begin
            valid_next = 1'b1;
        end
        else if (valid_reg && result_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= STEP_RATE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    assign item_ready   = (state_reg == ST_IDLE);
    assign result_valid = valid_reg;

endmodule

// ===== hw/rtl/angle_bias_kalman_filter_core.sv =====
// top level of the two-state angle and gyro bias kalman filter
// depends on abkf_pkg, abkf_ctrl, abkf_dp
//
//   channel   direction  handshake                     word
//   item      in         item_valid / item_ready       in_word_t
//   result    out        result_valid / result_ready   out_word_t
//   config    in         apb, pready tied high         31-bit noise registers
//
// one item at a time: item_ready is high only while idle, so the next item waits until
// the last one has been published to the output register
// asynchronous active-low reset clears state and covariance and loads the noise registers with their defaults
// a result waiting in the output register holds off only the finish of the next item

module angle_bias_kalman_filter_core
    import abkf_pkg::*;
#(
    parameter int DATA_WIDTH = ABKF_DATA_WIDTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_ready,
    input  in_word_t                    item,
    output logic                        result_valid,
    input  logic                        result_ready,
    output out_word_t                   result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ABKF_ADDR_WIDTH-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    logic [30:0]  angle_noise_reg;
    logic [30:0]  bias_noise_reg;
    logic [30:0]  meas_noise_reg;
    logic [1:0]   reg_index;
    dp_cmd_t      cmd;
    dp_status_t   status;

    assign reg_index = paddr[3:2];
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_noise_reg <= RESET_ANGLE_NOISE;
            bias_noise_reg  <= RESET_BIAS_NOISE;
            meas_noise_reg  <= RESET_MEAS_NOISE;
        end
        else if (psel && penable && pwrite)
        begin
            case (reg_index)
                REG_ANGLE_NOISE: angle_noise_reg <= pwdata[30:0];
                REG_BIAS_NOISE:  bias_noise_reg  <= pwdata[30:0];
                REG_MEAS_NOISE:  meas_noise_reg  <= pwdata[30:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_ANGLE_NOISE: prdata = {1'b0, angle_noise_reg};
            REG_BIAS_NOISE:  prdata = {1'b0, bias_noise_reg};
            REG_MEAS_NOISE:  prdata = {1'b0, meas_noise_reg};
            default:         prdata = '0;
        endcase
    end

    abkf_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cmd          (cmd),
        .status       (status)
    );

    abkf_dp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .item        (item),
        .angle_noise (angle_noise_reg),
        .bias_noise  (bias_noise_reg),
        .meas_noise  (meas_noise_reg),
        .result      (result)
    );

endmodule

// ===== hw/rtl/abkf_checker.sv =====
// port-level checks for the kalman filter core, attached by bind
// depends on abkf_pkg and angle_bias_kalman_filter_core
module abkf_checker
    import abkf_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    input  logic                        item_ready,
    input  logic                        result_valid,
    input  logic                        result_ready,
    input  out_word_t                   result
);
    // one word in flight: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("item accepted while a word was in flight");

    // a new result only appears at the end of work
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(!item_ready))
        else $error("result raised without work in progress");

    // the output register empties before it is refilled
    a_result_drains: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready |=> !result_valid)
        else $error("result register refilled in the cycle it drained");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("stalled result changed");

endmodule

bind angle_bias_kalman_filter_core abkf_checker u_abkf_checker (.*);
